>>> rtl/mrs_pkg.sv
// Shared types, constants and the CRC-16 byte update for the Modbus RTU slave responder.
// Used by every module of the block but mrs_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mrs_pkg;

    // Table and frame sizing
    localparam int BIT_TABLE_DEPTH  = 1024;
    localparam int WORD_TABLE_DEPTH = 256;
    localparam int MAX_FRAME_BYTES  = 255;
    localparam int MAX_DATA_BYTES   = MAX_FRAME_BYTES - 5;

    // Bit tables are split into eight banks so all eight bits of one data byte read at once
    localparam int BANK_COUNT = 8;
    localparam int BANK_DEPTH = BIT_TABLE_DEPTH / BANK_COUNT;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int WORD_AW    = (WORD_TABLE_DEPTH > 1) ? $clog2(WORD_TABLE_DEPTH) : 1;

    // Clearing pass covers the deepest memory
    localparam int CLR_DEPTH = (BANK_DEPTH > WORD_TABLE_DEPTH) ? BANK_DEPTH : WORD_TABLE_DEPTH;
    localparam int CLR_AW    = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [7:0]  EXC_FLAG = 8'h80;

    // Input ops
    localparam logic [1:0] OP_RX_BYTE = 2'd0;
    localparam logic [1:0] OP_WRITE   = 2'd1;
    localparam logic [1:0] OP_TX_SLOT = 2'd2;

    // Table selects
    localparam logic [1:0] TBL_COIL     = 2'd0;
    localparam logic [1:0] TBL_DISCRETE = 2'd1;
    localparam logic [1:0] TBL_HOLDING  = 2'd2;
    localparam logic [1:0] TBL_INPUT    = 2'd3;

    // Response kinds
    localparam logic [2:0] KIND_NONE      = 3'd0;
    localparam logic [2:0] KIND_COILS     = 3'd1;
    localparam logic [2:0] KIND_DISCRETE  = 3'd2;
    localparam logic [2:0] KIND_HOLDING   = 3'd3;
    localparam logic [2:0] KIND_INPUT     = 3'd4;
    localparam logic [2:0] KIND_EXCEPTION = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] REG_SLAVE_ID       = 2'd0;
    localparam logic [1:0] REG_MASTER_ROLE    = 2'd1;
    localparam logic [1:0] REG_EXCEPTION_MODE = 2'd2;
    localparam logic [1:0] REG_EXCEPTION_CODE = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  rx_byte;
        logic        frame_end;
        logic [1:0]  table_sel;
        logic [9:0]  table_index;
        logic [15:0] table_value;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } result_t;

    typedef struct packed {
        logic [7:0] slave_id;
        logic       master_role;
        logic       exception_mode;
        logic [7:0] exception_code;
    } cfg_t;

    // Class the front end gives each beat
    typedef enum logic [2:0] {
        CLS_NOP     = 3'd0,
        CLS_RX      = 3'd1,
        CLS_WR_BIT  = 3'd2,
        CLS_WR_WORD = 3'd3,
        CLS_TX      = 3'd4
    } cls_t;

    typedef struct packed {
        cls_t  cls;
        item_t item;
    } cmd_t;

    // Byte source in the output stage
    typedef enum logic [2:0] {
        SEL_CONST  = 3'd0,
        SEL_BITS   = 3'd1,
        SEL_WORD   = 3'd2,
        SEL_CRC_LO = 3'd3,
        SEL_CRC_HI = 3'd4
    } sel_t;

    // One reflected CRC-16 byte step
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/mrs_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read; read data holds while re is low
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/mrs_regs.sv
// APB configuration registers of the Modbus RTU slave responder.
// Depends on mrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrs_regs (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output mrs_pkg::cfg_t     cfg
);

    mrs_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    // Register writes on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slave_id       <= 8'd1;
            cfg_reg.master_role    <= 1'b0;
            cfg_reg.exception_mode <= 1'b0;
            cfg_reg.exception_code <= 8'd1;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                mrs_pkg::REG_SLAVE_ID:       cfg_reg.slave_id       <= pwdata[7:0];
                mrs_pkg::REG_MASTER_ROLE:    cfg_reg.master_role    <= pwdata[0];
                mrs_pkg::REG_EXCEPTION_MODE: cfg_reg.exception_mode <= pwdata[0];
                mrs_pkg::REG_EXCEPTION_CODE: cfg_reg.exception_code <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (reg_idx)
            mrs_pkg::REG_SLAVE_ID:       prdata = {24'd0, cfg_reg.slave_id};
            mrs_pkg::REG_MASTER_ROLE:    prdata = {31'd0, cfg_reg.master_role};
            mrs_pkg::REG_EXCEPTION_MODE: prdata = {31'd0, cfg_reg.exception_mode};
            mrs_pkg::REG_EXCEPTION_CODE: prdata = {24'd0, cfg_reg.exception_code};
            default:                     prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/mrs_front.sv
// Front end: accepts input beats, classifies them and holds them in a two-entry queue.
// Depends on mrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrs_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    output logic               item_ready,
    input  wire mrs_pkg::item_t item,
    input  wire logic          busy,
    output logic               q_valid,
    output mrs_pkg::cmd_t      q_cmd,
    input  wire logic          q_pop
);

    mrs_pkg::cmd_t entry_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    logic          push;
    mrs_pkg::cls_t cls;

    assign item_ready = (count_reg != 2'd2) && !busy;
    assign push       = item_valid && item_ready;
    assign q_valid    = (count_reg != 2'd0);
    assign q_cmd      = entry_reg[rd_ptr_reg];

    // Classify the incoming beat
    always_comb
    begin
        case (item.op)
            mrs_pkg::OP_RX_BYTE: cls = mrs_pkg::CLS_RX;
            mrs_pkg::OP_WRITE:   cls = item.table_sel[1] ? mrs_pkg::CLS_WR_WORD
                                                         : mrs_pkg::CLS_WR_BIT;
            mrs_pkg::OP_TX_SLOT: cls = mrs_pkg::CLS_TX;
            default:             cls = mrs_pkg::CLS_NOP;
        endcase
    end

    // Queue pointers
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= '{cls: cls, item: item};
        end
    end

endmodule

`default_nettype wire

>>> rtl/mrs_back.sv
// Back end: frame checking, response state, table memories and the byte output stage.
// Depends on mrs_pkg and mrs_ram.
`timescale 1ns / 1ps
`default_nettype none

module mrs_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire mrs_pkg::cfg_t cfg,
    input  wire logic          q_valid,
    input  wire mrs_pkg::cmd_t q_cmd,
    output logic               q_pop,
    output logic               busy,
    output logic               result_valid,
    input  wire logic          result_ready,
    output mrs_pkg::result_t   result
);

    localparam int BA = mrs_pkg::BANK_AW;
    localparam int WA = mrs_pkg::WORD_AW;
    localparam logic [mrs_pkg::CLR_AW-1:0] CLR_AW_LAST = mrs_pkg::CLR_AW'(mrs_pkg::CLR_DEPTH - 1);

    // Clearing pass
    logic                       clr_reg;
    logic [mrs_pkg::CLR_AW-1:0] clr_cnt_reg;

    // Receive and response state
    logic [3:0]  rx_count_reg, rx_count_next;
    logic [7:0]  rx_frame_reg [8];
    logic [15:0] rx_crc_reg, rx_crc_next;
    logic [2:0]  kind_reg, kind_next;
    logic [15:0] start_reg, start_next;
    logic [7:0]  nbytes_reg, nbytes_next;
    logic [7:0]  pos_reg, pos_next;

    // Output stage
    logic             s2_valid_reg;
    logic             s2_emit_reg, s2_emit_next;
    logic             s2_last_reg, s2_last_next;
    logic             s2_upd_reg, s2_upd_next;
    logic             s2_init_reg, s2_init_next;
    mrs_pkg::sel_t    s2_sel_reg, s2_sel_next;
    logic [7:0]       s2_const_reg, s2_const_next;
    logic             s2_disc_reg, s2_disc_next;
    logic             s2_inreg_reg, s2_inreg_next;
    logic [2:0]       s2_shift_reg, s2_shift_next;
    logic [7:0]       s2_mask_reg, s2_mask_next;
    logic             s2_wok_reg, s2_wok_next;
    logic             s2_lo_reg, s2_lo_next;
    logic [15:0]      tx_crc_reg;
    logic             res_valid_reg;
    mrs_pkg::result_t res_reg;

    logic s1_go, s2_fire, adv;

    // Memory ports
    logic [7:0]    coil_we, disc_we, coil_q, disc_q;
    logic [BA-1:0] bank_waddr, bank_raddr [8];
    logic          bit_wdata;
    logic          hold_we, inp_we;
    logic [WA-1:0] word_waddr, word_raddr;
    logic [15:0]   word_wdata, hold_q, inp_q;

    // Stage-one decode signals
    mrs_pkg::item_t it;
    logic        store, full;
    logic [3:0]  cnt_after;
    logic [7:0]  b7;
    logic [3:0]  fun;
    logic [15:0] qty;
    logic [16:0] nb;
    logic        frame_ok;
    logic [8:0]  len9, pos9;
    logic [7:0]  d;
    logic [16:0] base, ba, ak, wa, wi;
    logic [2:0]  off;
    logic [7:0]  data_byte;
    logic [7:0]  bits;
    logic [15:0] wsel;

    assign it           = q_cmd.item;
    assign busy         = clr_reg;
    assign s2_fire      = s2_valid_reg && (!s2_emit_reg || !res_valid_reg || result_ready);
    assign adv          = !s2_valid_reg || s2_fire;
    assign s1_go        = q_valid && adv && !clr_reg;
    assign q_pop        = s1_go;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // Stage one: receive, response bookkeeping, table addressing
    always_comb
    begin
        rx_count_next = rx_count_reg;
        rx_crc_next   = rx_crc_reg;
        kind_next     = kind_reg;
        start_next    = start_reg;
        nbytes_next   = nbytes_reg;
        pos_next      = pos_reg;
        s2_emit_next  = 1'b0;
        s2_last_next  = 1'b0;
        s2_upd_next   = 1'b0;
        s2_init_next  = 1'b0;
        s2_sel_next   = mrs_pkg::SEL_CONST;
        s2_const_next = 8'd0;
        s2_disc_next  = (kind_reg == mrs_pkg::KIND_DISCRETE);
        s2_inreg_next = (kind_reg == mrs_pkg::KIND_INPUT);

        store     = (rx_count_reg < 4'd8);
        cnt_after = store ? (rx_count_reg + 4'd1) : rx_count_reg;
        full      = (cnt_after == 4'd8);
        b7        = (rx_count_reg == 4'd7) ? it.rx_byte : rx_frame_reg[7];
        fun       = rx_frame_reg[1][3:0];
        qty       = {rx_frame_reg[4], rx_frame_reg[5]};
        frame_ok  = full && it.frame_end && (rx_frame_reg[0] == cfg.slave_id)
                    && (rx_crc_reg[7:0] == rx_frame_reg[6]) && (rx_crc_reg[15:8] == b7)
                    && !cfg.master_role;
        if (fun == 4'd1 || fun == 4'd2)
        begin
            nb = ({1'b0, qty} + 17'd7) >> 3;
        end
        else
        begin
            nb = {qty, 1'b0};
        end

        len9 = {1'b0, nbytes_reg} + 9'd5;
        pos9 = {1'b0, pos_reg};
        d    = pos_reg - 8'd3;

        // Bit-table addressing: eight consecutive bits, one per bank
        base = {1'b0, start_reg} + {6'd0, d, 3'd0};
        for (int k = 0; k < 8; k++)
        begin
            ak = base + 17'(k);
            s2_mask_next[k] = (ak < 17'(mrs_pkg::BIT_TABLE_DEPTH));
        end
        for (int b = 0; b < 8; b++)
        begin
            off = 3'(b) - base[2:0];
            ba  = base + {14'd0, off};
            bank_raddr[b] = ba[BA+2:3];
        end
        s2_shift_next = base[2:0];

        // Word-table addressing
        wa          = {1'b0, start_reg} + {10'd0, d[7:1]};
        word_raddr  = wa[WA-1:0];
        s2_wok_next = (wa < 17'(mrs_pkg::WORD_TABLE_DEPTH));
        s2_lo_next  = d[0];

        // Host write addressing
        wi         = {7'd0, it.table_index};
        bank_waddr = wi[BA+2:3];
        word_waddr = wi[WA-1:0];
        bit_wdata  = it.table_value[0];
        word_wdata = it.table_value;
        coil_we    = 8'd0;
        disc_we    = 8'd0;
        hold_we    = 1'b0;
        inp_we     = 1'b0;

        if (s1_go)
        begin
            case (q_cmd.cls)
                mrs_pkg::CLS_RX:
                begin
                    if (store && rx_count_reg < 4'd6)
                    begin
                        rx_crc_next = mrs_pkg::crc_byte(
                            (rx_count_reg == 4'd0) ? mrs_pkg::CRC_INIT : rx_crc_reg,
                            it.rx_byte);
                    end
                    rx_count_next = it.frame_end ? 4'd0 : cnt_after;
                    if (frame_ok)
                    begin
                        if (cfg.exception_mode)
                        begin
                            kind_next    = mrs_pkg::KIND_EXCEPTION;
                            start_next   = {12'd0, fun};
                            nbytes_next  = 8'd0;
                            pos_next     = 8'd0;
                            s2_init_next = 1'b1;
                        end
                        else if ((fun == 4'd1 || fun == 4'd2 || fun == 4'd3 || fun == 4'd4)
                                 && nb <= 17'(mrs_pkg::MAX_DATA_BYTES))
                        begin
                            kind_next    = fun[2:0];
                            start_next   = {rx_frame_reg[2], rx_frame_reg[3]};
                            nbytes_next  = nb[7:0];
                            pos_next     = 8'd0;
                            s2_init_next = 1'b1;
                        end
                    end
                end
                mrs_pkg::CLS_WR_BIT:
                begin
                    if (wi < 17'(mrs_pkg::BIT_TABLE_DEPTH))
                    begin
                        if (it.table_sel == mrs_pkg::TBL_COIL)
                        begin
                            coil_we[it.table_index[2:0]] = 1'b1;
                        end
                        else
                        begin
                            disc_we[it.table_index[2:0]] = 1'b1;
                        end
                    end
                end
                mrs_pkg::CLS_WR_WORD:
                begin
                    if (wi < 17'(mrs_pkg::WORD_TABLE_DEPTH))
                    begin
                        hold_we = (it.table_sel == mrs_pkg::TBL_HOLDING);
                        inp_we  = (it.table_sel == mrs_pkg::TBL_INPUT);
                    end
                end
                mrs_pkg::CLS_TX:
                begin
                    if (kind_reg != mrs_pkg::KIND_NONE)
                    begin
                        s2_emit_next = 1'b1;
                        s2_upd_next  = (pos9 < len9 - 9'd2);
                        if (pos_reg == 8'd0)
                        begin
                            s2_const_next = cfg.slave_id;
                        end
                        else if (pos_reg == 8'd1)
                        begin
                            s2_const_next = (kind_reg == mrs_pkg::KIND_EXCEPTION)
                                ? ({4'd0, start_reg[3:0]} | mrs_pkg::EXC_FLAG)
                                : {5'd0, kind_reg};
                        end
                        else if (pos_reg == 8'd2)
                        begin
                            s2_const_next = (kind_reg == mrs_pkg::KIND_EXCEPTION)
                                ? cfg.exception_code : nbytes_reg;
                        end
                        else if (pos9 < len9 - 9'd2)
                        begin
                            s2_sel_next = (kind_reg == mrs_pkg::KIND_COILS
                                           || kind_reg == mrs_pkg::KIND_DISCRETE)
                                ? mrs_pkg::SEL_BITS : mrs_pkg::SEL_WORD;
                        end
                        else if (pos9 == len9 - 9'd2)
                        begin
                            s2_sel_next = mrs_pkg::SEL_CRC_LO;
                        end
                        else
                        begin
                            s2_sel_next  = mrs_pkg::SEL_CRC_HI;
                            s2_last_next = 1'b1;
                        end
                        if (s2_last_next)
                        begin
                            kind_next = mrs_pkg::KIND_NONE;
                            pos_next  = 8'd0;
                        end
                        else
                        begin
                            pos_next = pos_reg + 8'd1;
                        end
                    end
                end
                default: ;
            endcase
        end

        // Clearing pass overrides all write ports
        if (clr_reg)
        begin
            coil_we    = 8'hFF;
            disc_we    = 8'hFF;
            hold_we    = 1'b1;
            inp_we     = 1'b1;
            bank_waddr = clr_cnt_reg[BA-1:0];
            word_waddr = clr_cnt_reg[WA-1:0];
            bit_wdata  = 1'b0;
            word_wdata = 16'd0;
        end
    end

    // Table memories
    for (genvar g = 0; g < mrs_pkg::BANK_COUNT; g++)
    begin : g_bank
        mrs_ram #(.WIDTH(1), .DEPTH(mrs_pkg::BANK_DEPTH)) u_coil (
            .clk(clk), .we(coil_we[g]), .waddr(bank_waddr), .wdata(bit_wdata),
            .re(adv), .raddr(bank_raddr[g]), .rdata(coil_q[g])
        );
        mrs_ram #(.WIDTH(1), .DEPTH(mrs_pkg::BANK_DEPTH)) u_disc (
            .clk(clk), .we(disc_we[g]), .waddr(bank_waddr), .wdata(bit_wdata),
            .re(adv), .raddr(bank_raddr[g]), .rdata(disc_q[g])
        );
    end

    mrs_ram #(.WIDTH(16), .DEPTH(mrs_pkg::WORD_TABLE_DEPTH)) u_hold (
        .clk(clk), .we(hold_we), .waddr(word_waddr), .wdata(word_wdata),
        .re(adv), .raddr(word_raddr), .rdata(hold_q)
    );
    mrs_ram #(.WIDTH(16), .DEPTH(mrs_pkg::WORD_TABLE_DEPTH)) u_inp (
        .clk(clk), .we(inp_we), .waddr(word_waddr), .wdata(word_wdata),
        .re(adv), .raddr(word_raddr), .rdata(inp_q)
    );

    // Stage two: byte select
    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            bits[k] = (s2_disc_reg ? disc_q[3'(s2_shift_reg + 3'(k))]
                                   : coil_q[3'(s2_shift_reg + 3'(k))]) & s2_mask_reg[k];
        end
        wsel = s2_wok_reg ? (s2_inreg_reg ? inp_q : hold_q) : 16'd0;
        case (s2_sel_reg)
            mrs_pkg::SEL_CONST:  data_byte = s2_const_reg;
            mrs_pkg::SEL_BITS:   data_byte = bits;
            mrs_pkg::SEL_WORD:   data_byte = s2_lo_reg ? wsel[7:0] : wsel[15:8];
            mrs_pkg::SEL_CRC_LO: data_byte = tx_crc_reg[7:0];
            mrs_pkg::SEL_CRC_HI: data_byte = tx_crc_reg[15:8];
            default:             data_byte = 8'd0;
        endcase
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= 1'b1;
            clr_cnt_reg   <= '0;
            rx_count_reg  <= 4'd0;
            rx_crc_reg    <= mrs_pkg::CRC_INIT;
            kind_reg      <= mrs_pkg::KIND_NONE;
            start_reg     <= 16'd0;
            nbytes_reg    <= 8'd0;
            pos_reg       <= 8'd0;
            s2_valid_reg  <= 1'b0;
            tx_crc_reg    <= mrs_pkg::CRC_INIT;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_AW_LAST)
                begin
                    clr_reg <= 1'b0;
                end
            end
            rx_count_reg <= rx_count_next;
            rx_crc_reg   <= rx_crc_next;
            kind_reg     <= kind_next;
            start_reg    <= start_next;
            nbytes_reg   <= nbytes_next;
            pos_reg      <= pos_next;
            if (adv)
            begin
                s2_valid_reg <= s1_go;
            end
            if (s2_fire)
            begin
                if (s2_init_reg || s2_last_reg)
                begin
                    tx_crc_reg <= mrs_pkg::CRC_INIT;
                end
                else if (s2_emit_reg && s2_upd_reg)
                begin
                    tx_crc_reg <= mrs_pkg::crc_byte(tx_crc_reg, data_byte);
                end
            end
            if (s2_fire && s2_emit_reg)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s1_go && q_cmd.cls == mrs_pkg::CLS_RX && store)
        begin
            rx_frame_reg[rx_count_reg[2:0]] <= it.rx_byte;
        end
        if (adv)
        begin
            s2_emit_reg  <= s2_emit_next;
            s2_last_reg  <= s2_last_next;
            s2_upd_reg   <= s2_upd_next;
            s2_init_reg  <= s2_init_next;
            s2_sel_reg   <= s2_sel_next;
            s2_const_reg <= s2_const_next;
            s2_disc_reg  <= s2_disc_next;
            s2_inreg_reg <= s2_inreg_next;
            s2_shift_reg <= s2_shift_next;
            s2_mask_reg  <= s2_mask_next;
            s2_wok_reg   <= s2_wok_next;
            s2_lo_reg    <= s2_lo_next;
        end
        if (s2_fire && s2_emit_reg)
        begin
            res_reg.out_byte <= data_byte;
            res_reg.out_last <= s2_last_reg;
        end
    end

endmodule

`default_nettype wire

>>> rtl/modbus_rtu_slave_responder.sv
// Modbus RTU slave responder for read functions 1-4: one beat per cycle unless the output stalls.
// Front queue (2 entries) -> decode/address stage -> table read and byte stage -> output register.
// A transmit slot's byte passes the front queue, the stage-two registers and the output register
// before it shows on result_valid; throughput is one beat per cycle unless result_ready stalls it.
// Reset is asynchronous, active low; after it a clearing pass over 256 entries zeroes all tables
// and item_ready stays low until it ends. Depends on mrs_pkg, mrs_regs, mrs_front, mrs_back.
`timescale 1ns / 1ps
`default_nettype none

module modbus_rtu_slave_responder (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [3:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic      [31:0]      prdata,
    output logic                  pready,
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire mrs_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output mrs_pkg::result_t      result
);

    mrs_pkg::cfg_t cfg;
    mrs_pkg::cmd_t q_cmd;
    logic          q_valid, q_pop, busy;

    assign pready = 1'b1;

    mrs_regs u_regs (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .cfg(cfg)
    );

    mrs_front u_front (
        .clk(clk), .rst_n(rst_n), .item_valid(item_valid), .item_ready(item_ready),
        .item(item), .busy(busy), .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
    );

    mrs_back u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg), .q_valid(q_valid), .q_cmd(q_cmd),
        .q_pop(q_pop), .busy(busy), .result_valid(result_valid),
        .result_ready(result_ready), .result(result)
    );

endmodule

`default_nettype wire

>>> rtl/mrs_checker.sv
// Port-level checks for the Modbus RTU slave responder, bound to the top level.
// Depends on mrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrs_checker (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [3:0]       paddr,
    input  wire logic [31:0]      pwdata,
    input  wire logic [31:0]      prdata,
    input  wire logic             result_valid,
    input  wire logic             result_ready,
    input  wire mrs_pkg::result_t result
);

    // A stalled result beat holds its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    // A slave id write reads back
    a_id_rb: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && paddr[3:2] == mrs_pkg::REG_SLAVE_ID
        |=> paddr[3:2] != mrs_pkg::REG_SLAVE_ID || prdata[7:0] == $past(pwdata[7:0]))
        else $error("slave id readback mismatch");

    // Registers are at most eight bits wide
    a_rd_width: assert property (@(posedge clk) disable iff (!rst_n)
        prdata[31:8] == 24'd0)
        else $error("unused read bits set");

endmodule

bind modbus_rtu_slave_responder mrs_checker u_mrs_checker (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .result_valid(result_valid),
    .result_ready(result_ready), .result(result)
);

`default_nettype wire
